// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked concurrent assertions in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lks_pkg.sv
// ----------------------------------------------------------------------------
// lks_pkg
// Constants, register indexes and arithmetic helpers of the keystream rotator.
// ----------------------------------------------------------------------------
package lks_pkg;

    localparam int CHAR_W     = 7;
    localparam int STATE_W    = 17;
    localparam int PROD_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [STATE_W-1:0] LKS_MULT    = 17'd75;
    localparam logic [STATE_W-1:0] LKS_MOD     = 17'd65537;
    localparam logic [STATE_W-1:0] LKS_RESET   = 17'd1;
    localparam logic [STATE_W-1:0] LKS_MAX     = 17'd65536;
    localparam logic [CHAR_W-1:0]  CHAR_BASE   = 7'd32;
    localparam logic [CHAR_W:0]    CHAR_SPAN   = 8'd96;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_SEED     = 2'd0,
        CFG_DECRYPT_MODE = 2'd1
    } cfg_idx_t;

    // One generator step: state * 75 mod 65537 by folding the product.
    function automatic logic [STATE_W-1:0] lks_advance(input logic [STATE_W-1:0] s);
        logic [PROD_W-1:0]  prod;
        logic [15:0]        lo;
        logic [7:0]         hi;
        logic [STATE_W:0]   diff;
        prod = PROD_W'(s) * PROD_W'(LKS_MULT);
        lo   = prod[15:0];
        hi   = prod[23:16];
        if (lo >= 16'(hi))
            diff = (STATE_W+1)'(lo) - (STATE_W+1)'(hi);
        else
            diff = (STATE_W+1)'(lo) + (STATE_W+1)'(LKS_MOD) - (STATE_W+1)'(hi);
        return diff[STATE_W-1:0];
    endfunction

    // r mod 96 = ((r >> 5) mod 3) * 32 + r[4:0]. The mod 3 uses the sum of
    // base-4 digits, since 4 is 1 modulo 3.
    function automatic logic [CHAR_W-1:0] lks_mod96(input logic [STATE_W-1:0] r);
        logic [4:0] dsum;
        logic [4:0] m;
        dsum = 5'(r[6:5]) + 5'(r[8:7]) + 5'(r[10:9])
             + 5'(r[12:11]) + 5'(r[14:13]) + 5'(r[16:15]);
        m = dsum;
        if (m >= 5'd12)
            m = m - 5'd12;
        if (m >= 5'd6)
            m = m - 5'd6;
        if (m >= 5'd3)
            m = m - 5'd3;
        return {m[1:0], r[4:0]};
    endfunction

    // Rotate a printable code within 32..127; control codes pass unchanged.
    function automatic logic [CHAR_W-1:0] lks_rotate(input logic [CHAR_W-1:0] c,
                                                     input logic [CHAR_W-1:0] k,
                                                     input logic             back);
        logic [CHAR_W:0] off;
        logic [CHAR_W:0] sum;
        if (c < CHAR_BASE)
            return c;
        off = (CHAR_W+1)'(c - CHAR_BASE);
        if (back)
            sum = off + CHAR_SPAN - (CHAR_W+1)'(k);
        else
            sum = off + (CHAR_W+1)'(k);
        if (sum >= CHAR_SPAN)
            sum = sum - CHAR_SPAN;
        return CHAR_W'(sum) + CHAR_BASE;
    endfunction

endpackage

// File: rtl/lehmer_keystream_char_rotator.sv
// ----------------------------------------------------------------------------
// lehmer_keystream_char_rotator
// Stream cipher that rotates printable 7-bit characters by a Lehmer keystream.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready with char_in. Output channel: out_valid /
// out_ready with char_out. Every character transfer yields exactly one result.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 writes the key seed and reloads the generator,
// index 1 selects decryption (1) or encryption (0); other indexes are ignored.
// Write configuration only while no character is in flight.
// Each accepted character advances the generator once, in the accept cycle;
// the new value is registered with the character. The next stage reduces it
// modulo 96 and rotates the character into the output register.
// A character passes through the stage-1 registers, then the output register,
// before it reaches char_out. Throughput is one character per cycle while
// out_ready holds, set by the single generator step per cycle.
// When the receiver stalls, the output register holds and the input stage
// keeps taking one more character before in_ready drops.
// Reset clears both stages, loads the generator with 1 and selects encryption.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lehmer_keystream_char_rotator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lks_pkg::CHAR_W-1:0]       char_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lks_pkg::CHAR_W-1:0]       char_out,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lks_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lks_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                          s1_valid_reg, s1_valid_next;
    logic                          out_valid_reg, out_valid_next;
    logic [lks_pkg::STATE_W-1:0]   gen_reg, gen_next;
    logic                          decrypt_reg, decrypt_next;
    logic [lks_pkg::CHAR_W-1:0]    s1_char_reg;
    logic [lks_pkg::STATE_W-1:0]   s1_key_reg;
    logic [lks_pkg::CHAR_W-1:0]    char_out_reg, char_out_next;
    logic [lks_pkg::STATE_W-1:0]   gen_adv;
    logic                          out_load;
    logic                          s1_fire;
    logic                          in_fire;
    logic                          cfg_fire;
    logic                          seed_wr;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign out_load = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_load;
    assign in_ready = !s1_valid_reg || out_load;
    assign in_fire  = in_valid && in_ready;

    assign gen_adv       = lks_pkg::lks_advance(gen_reg);
    assign char_out_next = lks_pkg::lks_rotate(s1_char_reg,
                                               lks_pkg::lks_mod96(s1_key_reg),
                                               decrypt_reg);

    always_comb
    begin
        seed_wr      = 1'b0;
        decrypt_next = decrypt_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                lks_pkg::CFG_KEY_SEED:     seed_wr = 1'b1;
                lks_pkg::CFG_DECRYPT_MODE: decrypt_next = cfg_data[0];
                default:                   seed_wr = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        if (seed_wr)
            gen_next = cfg_data;
        else if (in_fire)
            gen_next = gen_adv;
        else
            gen_next = gen_reg;

        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            gen_reg       <= lks_pkg::LKS_RESET;
            decrypt_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            gen_reg       <= gen_next;
            decrypt_reg   <= decrypt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg <= char_in;
            s1_key_reg  <= gen_adv;
        end
        if (s1_fire)
            char_out_reg <= char_out_next;
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;

    // Control codes must leave the block exactly as they came in.
    `ASSERT_NEXT(a_ctrl_pass, s1_fire && (s1_char_reg < lks_pkg::CHAR_BASE),
                 char_out == $past(s1_char_reg), "control character was altered")

    // Printable codes stay printable after rotation.
    `ASSERT_NEXT(a_print_stays, s1_fire && (s1_char_reg >= lks_pkg::CHAR_BASE),
                 char_out >= lks_pkg::CHAR_BASE, "printable character left 32..127")

    // A generator step always lands in the reduced range.
    `ASSERT_NEXT(a_gen_range, in_fire && !seed_wr, gen_reg <= lks_pkg::LKS_MAX,
                 "generator state above 65536 after a step")

    // Back-pressure only when both stages hold a character.
    `ASSERT_CLK(a_ready_full, !in_ready |-> (s1_valid_reg && out_valid_reg),
                "input stalled while a stage was free")

endmodule
